FILE: hdl/curl_ternary_sponge_transform_unit_macros.svh
// Assertion macros used by the sponge transform unit.
`ifndef CURL_TERNARY_SPONGE_TRANSFORM_UNIT_MACROS_SVH
`define CURL_TERNARY_SPONGE_TRANSFORM_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CTST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define CTST_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

FILE: hdl/ctst_pkg.sv
// Types, constants and the S-box of the ternary sponge transform.
package ctst_pkg;

  localparam int unsigned TRIT_W      = 2;
  localparam int unsigned ROW_TRITS   = 27;
  localparam int unsigned ROW_W       = ROW_TRITS * TRIT_W;
  localparam int unsigned STATE_TRITS = 729;
  localparam int unsigned STATE_ROWS  = STATE_TRITS / ROW_TRITS;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned COL_W       = 5;
  localparam int unsigned ROW_AW      = 5;
  localparam int unsigned LOAD_W      = 10;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned STATUS_W    = 2;

  localparam int unsigned READS_PER_ROUND = STATE_TRITS + 1;

  localparam logic [LOAD_W-1:0] STEP_UP      = LOAD_W'(364);
  localparam logic [LOAD_W-1:0] STEP_DN      = LOAD_W'(365);
  localparam logic [ROW_AW-1:0] STEP_ROWS    = ROW_AW'(13);
  localparam logic [COL_W-1:0]  STEP_UP_COLS = COL_W'(13);
  localparam logic [COL_W-1:0]  STEP_DN_COLS = COL_W'(14);
  localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(ROW_TRITS - 1);
  localparam logic [ROW_AW-1:0] LAST_ROW     = ROW_AW'(STATE_ROWS - 1);

  typedef logic [TRIT_W-1:0] trit_t;
  typedef logic [ROW_W-1:0]  row_t;

  localparam trit_t TRIT_ZERO = 2'b00;
  localparam trit_t TRIT_POS  = 2'b01;
  localparam trit_t TRIT_BAD  = 2'b10;
  localparam trit_t TRIT_NEG  = 2'b11;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TRIT = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  localparam trit_t SBOX [9] = '{TRIT_POS, TRIT_ZERO, TRIT_NEG, TRIT_POS, TRIT_NEG,
                                 TRIT_ZERO, TRIT_NEG, TRIT_POS, TRIT_ZERO};

  // New trit from the trit at the walk index (a) and the one it steps to (b).
  function automatic trit_t sbox_f(trit_t a, trit_t b);
    logic [3:0] idx;
    idx = 4'd4;
    case (a)
      TRIT_POS: idx = idx + 4'd1;
      TRIT_NEG: idx = idx - 4'd1;
      default:  idx = idx;
    endcase
    case (b)
      TRIT_POS: idx = idx + 4'd3;
      TRIT_NEG: idx = idx - 4'd3;
      default:  idx = idx;
    endcase
    return SBOX[idx];
  endfunction

endpackage

FILE: hdl/ctst_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ctst_ram #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = 27
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/curl_ternary_sponge_transform_unit.sv
// Curl ternary sponge transform: trit loader, permutation over a RAM-held state, result emitter.
//
// Input words carry up to 27 two-bit trits each; tlast marks the final word of a message.
// Each accepted word is merged into the state, and s_axis_tready stays high
// while a message loads. The final word starts the permutation, which runs over two
// 27 x 54-bit state RAMs used in ping-pong fashion: one trit is read per cycle from the
// single read port, for ROUND_COUNT rounds. A flush state comes first and writes any partial
// last row. Results leave as words of 27 trits; the emitter reads one row at a time and
// only while the output register is free, so a stall simply holds the output register
// and the emitter.
// A message with a bad trit code or more than 729 trits returns a single word with a
// zero count and the error status in tuser; so does an empty message, with status 0.
// The next message may load while the last result word is still waiting.
// Reset clears all control state; no RAM clearing pass is needed, as rows beyond the
// loaded fill count read as zero during the first round.
module curl_ternary_sponge_transform_unit #(
  parameter int unsigned ROUND_COUNT    = 27,
  parameter int unsigned TRITS_PER_ITEM = 27
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: trit_group [53:0], valid_count [58:54], zero fill.
  input  logic [ctst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: result_group [53:0], result_count [58:54], zero fill.
  output logic [ctst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,
  // Fields from bit 0: status [1:0].
  output logic [ctst_pkg::STATUS_W-1:0]      m_axis_tuser
);

  import ctst_pkg::*;

`include "curl_ternary_sponge_transform_unit_macros.svh"

  localparam int unsigned RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);
  localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(TRITS_PER_ITEM);

  typedef enum logic [1:0] {ST_LOAD, ST_FLUSH, ST_PERM, ST_EMIT} state_e;

  state_e              state_q, state_d;
  logic [LOAD_W-1:0]   loaded_q, loaded_d;
  status_e             err_q, err_d;
  logic [ROW_AW-1:0]   l_row_q, l_row_d;
  logic [COL_W-1:0]    l_col_q, l_col_d;
  row_t                lbuf_q, lbuf_d;
  logic [ROW_AW-1:0]   fill_rows_q, fill_rows_d;
  logic [CNT_W-1:0]    last_cnt_q, last_cnt_d;
  logic [RND_W-1:0]    round_q, round_d;
  logic                src_q, src_d;
  logic [LOAD_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [LOAD_W-1:0]   p_lin_q, p_lin_d;
  logic [ROW_AW-1:0]   p_row_q, p_row_d;
  logic [COL_W-1:0]    p_col_q, p_col_d;
  logic                s1_vld_q, s1_vld_d;
  logic [COL_W-1:0]    s1_col_q, s1_col_d;
  logic                s1_zero_q, s1_zero_d;
  trit_t               prev_q, prev_d;
  logic                have_prev_q, have_prev_d;
  logic [ROW_AW-1:0]   w_row_q, w_row_d;
  logic [COL_W-1:0]    w_col_q, w_col_d;
  row_t                wbuf_q, wbuf_d;
  logic [ROW_AW-1:0]   e_row_q, e_row_d;
  logic                e_inflight_q, e_inflight_d;
  logic                e_last_q, e_last_d;
  logic [CNT_W-1:0]    e_cnt_q, e_cnt_d;
  logic                m_vld_q, m_vld_d;
  row_t                m_group_q, m_group_d;
  logic [CNT_W-1:0]    m_cnt_q, m_cnt_d;
  logic                m_last_q, m_last_d;
  status_e             m_status_q, m_status_d;

  row_t                in_group;
  logic [CNT_W-1:0]    in_cnt;
  logic [CNT_W-1:0]    sat_cnt;
  logic [LOAD_W-1:0]   room;
  logic                overflow;
  logic [CNT_W-1:0]    n_store;
  row_t                clean;
  logic                any_bad;
  logic [2*ROW_W-1:0]  merged;
  logic [COL_W:0]      col_sum;
  logic                row_done;

  row_t                rdata0, rdata1, rdata;
  trit_t               a_trit;
  trit_t               new_trit;
  row_t                wbuf_ins;
  row_t                e_group;
  logic                out_free;

  logic                wr_en;
  logic                wr_bank;
  logic [ROW_AW-1:0]   wr_addr;
  row_t                wr_data;
  logic [ROW_AW-1:0]   rd_addr;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - ROW_W - CNT_W)'(0), m_cnt_q, m_group_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_status_q;
  assign out_free      = !m_vld_q || m_axis_tready;

  // Loader: saturate the count, clean the trits and funnel them into the row buffer.
  assign in_group = s_axis_tdata[ROW_W-1:0];
  assign in_cnt   = s_axis_tdata[ROW_W +: CNT_W];
  assign sat_cnt  = (in_cnt > MAX_CNT) ? MAX_CNT : in_cnt;
  assign room     = LOAD_W'(STATE_TRITS) - loaded_q;
  assign overflow = LOAD_W'(sat_cnt) > room;
  assign n_store  = overflow ? room[CNT_W-1:0] : sat_cnt;

  always_comb begin
    clean   = '0;
    any_bad = 1'b0;
    for (int k = 0; k < ROW_TRITS; k++) begin
      if ((CNT_W'(k) < sat_cnt) && (in_group[TRIT_W*k +: TRIT_W] == TRIT_BAD)) begin
        any_bad = 1'b1;
      end
      if ((CNT_W'(k) < n_store) && (in_group[TRIT_W*k +: TRIT_W] != TRIT_BAD)) begin
        clean[TRIT_W*k +: TRIT_W] = in_group[TRIT_W*k +: TRIT_W];
      end
    end
  end

  assign merged   = {ROW_W'(0), lbuf_q} | ({ROW_W'(0), clean} << {l_col_q, 1'b0});
  assign col_sum  = {1'b0, l_col_q} + {1'b0, n_store};
  assign row_done = col_sum >= (COL_W + 1)'(ROW_TRITS);

  // Permutation datapath: pick the trit out of the row read last cycle.
  assign rdata    = src_q ? rdata1 : rdata0;
  assign a_trit   = s1_zero_q ? TRIT_ZERO : rdata[{s1_col_q, 1'b0} +: TRIT_W];
  assign new_trit = sbox_f(prev_q, a_trit);

  always_comb begin
    wbuf_ins = wbuf_q;
    wbuf_ins[{w_col_q, 1'b0} +: TRIT_W] = new_trit;
  end

  always_comb begin
    e_group = '0;
    for (int k = 0; k < ROW_TRITS; k++) begin
      if (CNT_W'(k) < e_cnt_q) begin
        e_group[TRIT_W*k +: TRIT_W] = rdata[TRIT_W*k +: TRIT_W];
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_bank = 1'b0;
    wr_addr = l_row_q;
    wr_data = merged[ROW_W-1:0];
    unique case (state_q)
      ST_LOAD: begin
        wr_en = s_axis_tvalid && row_done;
      end
      ST_FLUSH: begin
        wr_en   = (err_q == STATUS_OK) && (loaded_q != '0) && (l_col_q != '0);
        wr_data = lbuf_q;
      end
      ST_PERM: begin
        wr_en   = s1_vld_q && have_prev_q && (w_col_q == LAST_COL);
        wr_bank = !src_q;
        wr_addr = w_row_q;
        wr_data = wbuf_ins;
      end
      ST_EMIT: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = (state_q == ST_EMIT) ? e_row_q : p_row_q;

  ctst_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STATE_ROWS)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (wr_en && !wr_bank),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  ctst_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STATE_ROWS)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (wr_en && wr_bank),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    err_d        = err_q;
    l_row_d      = l_row_q;
    l_col_d      = l_col_q;
    lbuf_d       = lbuf_q;
    fill_rows_d  = fill_rows_q;
    last_cnt_d   = last_cnt_q;
    round_d      = round_q;
    src_d        = src_q;
    rd_cnt_d     = rd_cnt_q;
    p_lin_d      = p_lin_q;
    p_row_d      = p_row_q;
    p_col_d      = p_col_q;
    s1_vld_d     = 1'b0;
    s1_col_d     = s1_col_q;
    s1_zero_d    = s1_zero_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    w_row_d      = w_row_q;
    w_col_d      = w_col_q;
    wbuf_d       = wbuf_q;
    e_row_d      = e_row_q;
    e_inflight_d = e_inflight_q;
    e_last_d     = e_last_q;
    e_cnt_d      = e_cnt_q;
    m_vld_d      = m_vld_q && !m_axis_tready;
    m_group_d    = m_group_q;
    m_cnt_d      = m_cnt_q;
    m_last_d     = m_last_q;
    m_status_d   = m_status_q;

    unique case (state_q)
      ST_LOAD: begin
        if (s_axis_tvalid) begin
          loaded_d = loaded_q + LOAD_W'(n_store);
          if (overflow) begin
            err_d = STATUS_OVERFLOW;
          end else if ((err_q == STATUS_OK) && any_bad) begin
            err_d = STATUS_BAD_TRIT;
          end
          if (row_done) begin
            lbuf_d  = merged[2*ROW_W-1:ROW_W];
            l_col_d = COL_W'(col_sum - (COL_W + 1)'(ROW_TRITS));
            l_row_d = l_row_q + ROW_AW'(1);
          end else begin
            lbuf_d  = merged[ROW_W-1:0];
            l_col_d = col_sum[COL_W-1:0];
          end
          if (s_axis_tlast) begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if ((err_q != STATUS_OK) || (loaded_q == '0)) begin
          if (out_free) begin
            m_vld_d    = 1'b1;
            m_group_d  = '0;
            m_cnt_d    = '0;
            m_last_d   = 1'b1;
            m_status_d = err_q;
            loaded_d   = '0;
            err_d      = STATUS_OK;
            l_row_d    = '0;
            l_col_d    = '0;
            lbuf_d     = '0;
            state_d    = ST_LOAD;
          end
        end else begin
          fill_rows_d = l_row_q + ROW_AW'(l_col_q != '0);
          last_cnt_d  = (l_col_q == '0) ? CNT_W'(ROW_TRITS) : l_col_q;
          round_d     = '0;
          src_d       = 1'b0;
          rd_cnt_d    = '0;
          p_lin_d     = '0;
          p_row_d     = '0;
          p_col_d     = '0;
          have_prev_d = 1'b0;
          w_row_d     = '0;
          w_col_d     = '0;
          state_d     = ST_PERM;
        end
      end

      ST_PERM: begin
        if (rd_cnt_q < LOAD_W'(READS_PER_ROUND)) begin
          rd_cnt_d  = rd_cnt_q + LOAD_W'(1);
          s1_vld_d  = 1'b1;
          s1_col_d  = p_col_q;
          s1_zero_d = (round_q == '0) && (p_row_q >= fill_rows_q);
          if (p_lin_q < STEP_DN) begin
            p_lin_d = p_lin_q + STEP_UP;
            if (p_col_q >= STEP_DN_COLS) begin
              p_col_d = p_col_q - STEP_DN_COLS;
              p_row_d = p_row_q + STEP_ROWS + ROW_AW'(1);
            end else begin
              p_col_d = p_col_q + STEP_UP_COLS;
              p_row_d = p_row_q + STEP_ROWS;
            end
          end else begin
            p_lin_d = p_lin_q - STEP_DN;
            if (p_col_q < STEP_DN_COLS) begin
              p_col_d = p_col_q + STEP_UP_COLS;
              p_row_d = p_row_q - STEP_ROWS - ROW_AW'(1);
            end else begin
              p_col_d = p_col_q - STEP_DN_COLS;
              p_row_d = p_row_q - STEP_ROWS;
            end
          end
        end
        if (s1_vld_q) begin
          prev_d      = a_trit;
          have_prev_d = 1'b1;
          if (have_prev_q) begin
            wbuf_d = wbuf_ins;
            if (w_col_q == LAST_COL) begin
              w_col_d = '0;
              w_row_d = w_row_q + ROW_AW'(1);
              if (w_row_q == LAST_ROW) begin
                src_d       = !src_q;
                rd_cnt_d    = '0;
                p_lin_d     = '0;
                p_row_d     = '0;
                p_col_d     = '0;
                s1_vld_d    = 1'b0;
                have_prev_d = 1'b0;
                w_row_d     = '0;
                if (round_q == LAST_ROUND) begin
                  e_row_d      = '0;
                  e_inflight_d = 1'b0;
                  state_d      = ST_EMIT;
                end else begin
                  round_d = round_q + RND_W'(1);
                end
              end
            end else begin
              w_col_d = w_col_q + COL_W'(1);
            end
          end
        end
      end

      ST_EMIT: begin
        if (e_inflight_q) begin
          e_inflight_d = 1'b0;
          m_vld_d      = 1'b1;
          m_group_d    = e_group;
          m_cnt_d      = e_cnt_q;
          m_last_d     = e_last_q;
          m_status_d   = STATUS_OK;
          if (e_last_q) begin
            loaded_d = '0;
            err_d    = STATUS_OK;
            l_row_d  = '0;
            l_col_d  = '0;
            lbuf_d   = '0;
            state_d  = ST_LOAD;
          end
        end else if (out_free) begin
          e_inflight_d = 1'b1;
          e_row_d      = e_row_q + ROW_AW'(1);
          e_last_d     = (e_row_q == (fill_rows_q - ROW_AW'(1)));
          e_cnt_d      = (e_row_q == (fill_rows_q - ROW_AW'(1))) ? last_cnt_q
                                                                 : CNT_W'(ROW_TRITS);
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      loaded_q     <= '0;
      err_q        <= STATUS_OK;
      l_row_q      <= '0;
      l_col_q      <= '0;
      lbuf_q       <= '0;
      fill_rows_q  <= '0;
      last_cnt_q   <= '0;
      round_q      <= '0;
      src_q        <= 1'b0;
      rd_cnt_q     <= '0;
      p_lin_q      <= '0;
      p_row_q      <= '0;
      p_col_q      <= '0;
      s1_vld_q     <= 1'b0;
      s1_col_q     <= '0;
      s1_zero_q    <= 1'b0;
      prev_q       <= TRIT_ZERO;
      have_prev_q  <= 1'b0;
      w_row_q      <= '0;
      w_col_q      <= '0;
      wbuf_q       <= '0;
      e_row_q      <= '0;
      e_inflight_q <= 1'b0;
      e_last_q     <= 1'b0;
      e_cnt_q      <= '0;
      m_vld_q      <= 1'b0;
      m_group_q    <= '0;
      m_cnt_q      <= '0;
      m_last_q     <= 1'b0;
      m_status_q   <= STATUS_OK;
    end else begin
      state_q      <= state_d;
      loaded_q     <= loaded_d;
      err_q        <= err_d;
      l_row_q      <= l_row_d;
      l_col_q      <= l_col_d;
      lbuf_q       <= lbuf_d;
      fill_rows_q  <= fill_rows_d;
      last_cnt_q   <= last_cnt_d;
      round_q      <= round_d;
      src_q        <= src_d;
      rd_cnt_q     <= rd_cnt_d;
      p_lin_q      <= p_lin_d;
      p_row_q      <= p_row_d;
      p_col_q      <= p_col_d;
      s1_vld_q     <= s1_vld_d;
      s1_col_q     <= s1_col_d;
      s1_zero_q    <= s1_zero_d;
      prev_q       <= prev_d;
      have_prev_q  <= have_prev_d;
      w_row_q      <= w_row_d;
      w_col_q      <= w_col_d;
      wbuf_q       <= wbuf_d;
      e_row_q      <= e_row_d;
      e_inflight_q <= e_inflight_d;
      e_last_q     <= e_last_d;
      e_cnt_q      <= e_cnt_d;
      m_vld_q      <= m_vld_d;
      m_group_q    <= m_group_d;
      m_cnt_q      <= m_cnt_d;
      m_last_q     <= m_last_d;
      m_status_q   <= m_status_d;
    end
  end

  `CTST_ASSERT_IMP(a_err_word_form, m_vld_q && (m_status_q != STATUS_OK),
                   (m_cnt_q == '0) && m_last_q, "error word carries trits or is not last")
  `CTST_ASSERT_IMP(a_perm_bank_split, wr_en && (state_q == ST_PERM), wr_bank != src_q,
                   "permutation writes the bank it reads")
  `CTST_ASSERT(a_rd_cnt_range, rd_cnt_q <= LOAD_W'(READS_PER_ROUND),
               "walk read counter out of range")
  `CTST_ASSERT_IMP(a_emit_slot_free, e_inflight_q, !m_vld_q,
                   "emitted row lands on a full output register")

endmodule
